@@ sv/sspc_pkg.sv @@
// Shared types and constants for the servo status packet checker.
// Depends on nothing; the configuration interface, the CRC update and the top level use it by scoped names.
package sspc_pkg;

	// Result status codes
	typedef enum logic [2:0] {
		STATUS_OK        = 3'd0,
		STATUS_HEADER    = 3'd1,
		STATUS_ID        = 3'd2,
		STATUS_CRC       = 3'd3,
		STATUS_TRUNCATED = 3'd4
	} status_t;

	// Configuration register indexes
	localparam int unsigned CFG_IDX_W = 2;
	typedef enum logic [CFG_IDX_W-1:0] {
		REG_EXPECTED_ID = 2'd0,
		REG_CHECK_ID    = 2'd1,
		REG_DATA_FORMAT = 2'd2
	} cfg_index_t;

	// Data format codes
	typedef enum logic [2:0] {
		FMT_INT8   = 3'd0,
		FMT_UINT8  = 3'd1,
		FMT_INT16  = 3'd2,
		FMT_UINT16 = 3'd3,
		FMT_INT32  = 3'd4,
		FMT_UINT32 = 3'd5
	} data_format_t;

	localparam logic [15:0] CRC_POLY = 16'h8005;

	// Packet layout
	localparam logic [4:0] FIXED_BYTES = 5'd11;
	localparam logic [3:0] POS_ID      = 4'd4;
	localparam logic [3:0] POS_DATA    = 4'd9;
	localparam logic [3:0] HEADER_LEN  = 4'd4;

	localparam logic [7:0] EXPECTED_ID_RESET = 8'd1;
	localparam logic [2:0] DATA_FORMAT_RESET = 3'd4;

	// Expected header byte at positions 0 to 3
	function automatic logic [7:0] header_byte(input logic [1:0] pos);
		logic [7:0] b;
		case (pos)
			2'd0:    b = 8'hFF;
			2'd1:    b = 8'hFF;
			2'd2:    b = 8'hFD;
			default: b = 8'h00;
		endcase
		return b;
	endfunction

	// Data size in bytes for a format code, before the size cap
	function automatic logic [4:0] format_size(input logic [2:0] fmt);
		logic [4:0] s;
		case (fmt)
			FMT_INT8, FMT_UINT8:   s = 5'd1;
			FMT_INT16, FMT_UINT16: s = 5'd2;
			default:               s = 5'd4;
		endcase
		return s;
	endfunction

endpackage

@@ sv/sspc_in_if.sv @@
// Input byte channel of the servo status packet checker.
// Depends on nothing.
interface sspc_in_if;
	logic       valid;
	logic       ready;
	logic [7:0] rx_byte;
	logic       packet_start;

	modport source (output valid, output rx_byte, output packet_start, input ready);
	modport sink (input valid, input rx_byte, input packet_start, output ready);
endinterface

@@ sv/sspc_out_if.sv @@
// Result channel of the servo status packet checker.
// Depends on nothing.
interface sspc_out_if;
	logic               valid;
	logic               ready;
	logic [2:0]         status;
	logic [7:0]         reply_id;
	logic signed [32:0] value;

	modport source (output valid, output status, output reply_id, output value, input ready);
	modport sink (input valid, input status, input reply_id, input value, output ready);
endinterface

@@ sv/sspc_cfg_if.sv @@
// Configuration write channel of the servo status packet checker.
// Depends on sspc_pkg for the register index width.
interface sspc_cfg_if;
	logic                          valid;
	logic                          ready;
	logic [sspc_pkg::CFG_IDX_W-1:0] index;
	logic [7:0]                    data;

	modport source (output valid, output index, output data, input ready);
	modport sink (input valid, input index, input data, output ready);
endinterface

@@ sv/sspc_crc16_byte.sv @@
// One-byte update of CRC-16, polynomial 0x8005, MSB first.
// Depends on sspc_pkg for the polynomial.
module sspc_crc16_byte (
	input  logic [15:0] crc,
	input  logic [7:0]  data,
	output logic [15:0] crc_next
);

	// Shift eight bits through the polynomial
	always_comb begin
		logic [15:0] c;
		c = crc ^ {data, 8'h00};
		for (int k = 0; k < 8; k++) begin
			if (c[15]) begin
				c = {c[14:0], 1'b0} ^ sspc_pkg::CRC_POLY;
			end else begin
				c = {c[14:0], 1'b0};
			end
		end
		crc_next = c;
	end

endmodule

@@ sv/servo_status_packet_checker.sv @@
// Servo status packet checker: top level with framing state and result register.
// Depends on sspc_pkg, sspc_in_if, sspc_out_if, sspc_cfg_if and sspc_crc16_byte.
//
// The block takes one byte of a protocol-2 status packet per transfer on rx,
// with packet_start marking the first byte, and gives one result per packet on
// result: header check, optional ID check, CRC-16 check and the decoded data
// value. It accepts one byte every clock cycle; each byte is handled in the
// cycle it is accepted by a combinational byte-wide CRC update and framing
// logic, and its result lands in one output register. rx stalls only while
// that register holds a result that result has not taken. Configuration
// writes are taken every cycle and should be made while no packet is open.
module servo_status_packet_checker #(
	parameter int MAX_DATA_BYTES = 4
) (
	input  logic clk,
	input  logic arst_n,
	sspc_in_if.sink    rx,
	sspc_out_if.source result,
	sspc_cfg_if.sink   cfg
);

	localparam int         DATA_W    = 8 * MAX_DATA_BYTES;
	localparam logic [4:0] MAX_BYTES = 5'(MAX_DATA_BYTES);

	// Configuration registers
	logic [7:0] expected_id_q;
	logic       check_id_q;
	logic [2:0] data_format_q;

	// Packet state
	logic [3:0]        pos_q;
	logic              in_packet_q;
	logic [15:0]       crc_q;
	logic              header_good_q;
	logic [7:0]        id_q;
	logic [DATA_W-1:0] data_q;
	logic [7:0]        crc_low_q;

	// Result register
	logic               out_valid_q;
	logic [2:0]         out_status_q;
	logic [7:0]         out_id_q;
	logic signed [32:0] out_value_q;

	logic rx_xfer;
	logic start;
	logic active;
	logic [3:0]        pos_base;
	logic [15:0]       crc_base;
	logic              header_base;
	logic [7:0]        id_base;
	logic [DATA_W-1:0] data_base;
	logic [7:0]        crc_low_base;
	logic [4:0]        size;
	logic [4:0]        total;
	logic [4:0]        pos_ext;
	logic              feed;
	logic              take_crc_low;
	logic              finish;
	logic              truncate;
	logic [15:0]       crc_fed;
	logic [15:0]       crc_next;
	logic              header_next;
	logic [7:0]        id_next;
	logic [DATA_W-1:0] data_next;
	logic [31:0]       data_wide;
	logic [15:0]       rx_crc;
	sspc_pkg::status_t fin_status;
	logic signed [32:0] decoded;

	assign cfg.ready = 1'b1;
	assign rx.ready  = !out_valid_q || result.ready;
	assign rx_xfer   = rx.valid && rx.ready;

	// Configuration writes; indexes past the list are dropped
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			expected_id_q <= sspc_pkg::EXPECTED_ID_RESET;
			check_id_q    <= 1'b1;
			data_format_q <= sspc_pkg::DATA_FORMAT_RESET;
		end else if (cfg.valid && cfg.ready) begin
			case (cfg.index)
				sspc_pkg::REG_EXPECTED_ID: expected_id_q <= cfg.data;
				sspc_pkg::REG_CHECK_ID:    check_id_q    <= cfg.data[0];
				sspc_pkg::REG_DATA_FORMAT: data_format_q <= cfg.data[2:0];
				default: ;
			endcase
		end
	end

	// Start of packet reopens the state
	assign start        = rx.packet_start;
	assign active       = start || in_packet_q;
	assign truncate     = start && in_packet_q;
	assign pos_base     = start ? 4'd0 : pos_q;
	assign crc_base     = start ? 16'h0000 : crc_q;
	assign header_base  = start ? 1'b1 : header_good_q;
	assign id_base      = start ? 8'h00 : id_q;
	assign data_base    = start ? '0 : data_q;
	assign crc_low_base = start ? 8'h00 : crc_low_q;

	// Packet length from the live format, capped by the data lanes
	always_comb begin
		logic [4:0] s;
		s = sspc_pkg::format_size(data_format_q);
		size = (s > MAX_BYTES) ? MAX_BYTES : s;
	end
	assign total        = sspc_pkg::FIXED_BYTES + size;
	assign pos_ext      = {1'b0, pos_base};
	assign feed         = (pos_ext + 5'd2) < total;
	assign take_crc_low = (pos_ext + 5'd2) == total;
	assign finish       = (pos_ext + 5'd1) >= total;

	sspc_crc16_byte u_crc (
		.crc      (crc_base),
		.data     (rx.rx_byte),
		.crc_next (crc_fed)
	);
	assign crc_next = feed ? crc_fed : crc_base;

	// Header, ID and data capture
	always_comb begin
		header_next = header_base;
		id_next     = id_base;
		data_next   = data_base;
		if (feed) begin
			if (pos_base < sspc_pkg::HEADER_LEN) begin
				if (rx.rx_byte != sspc_pkg::header_byte(pos_base[1:0])) begin
					header_next = 1'b0;
				end
			end else if (pos_base == sspc_pkg::POS_ID) begin
				id_next = rx.rx_byte;
			end
			for (int i = 0; i < MAX_DATA_BYTES; i++) begin
				if ((pos_base == sspc_pkg::POS_DATA + 4'(i)) && (5'(i) < size)) begin
					data_next[8*i +: 8] = rx.rx_byte;
				end
			end
		end
	end

	// Final checks in priority order
	assign rx_crc = {rx.rx_byte, crc_low_base};
	always_comb begin
		if (!header_next) begin
			fin_status = sspc_pkg::STATUS_HEADER;
		end else if (check_id_q && (id_next != expected_id_q)) begin
			fin_status = sspc_pkg::STATUS_ID;
		end else if (rx_crc != crc_base) begin
			fin_status = sspc_pkg::STATUS_CRC;
		end else begin
			fin_status = sspc_pkg::STATUS_OK;
		end
	end

	// Extend the data by type
	assign data_wide = 32'(data_next);
	always_comb begin
		case (data_format_q)
			sspc_pkg::FMT_INT8:   decoded = {{25{data_wide[7]}}, data_wide[7:0]};
			sspc_pkg::FMT_UINT8:  decoded = {25'd0, data_wide[7:0]};
			sspc_pkg::FMT_INT16:  decoded = {{17{data_wide[15]}}, data_wide[15:0]};
			sspc_pkg::FMT_UINT16: decoded = {17'd0, data_wide[15:0]};
			sspc_pkg::FMT_INT32:  decoded = {data_wide[31], data_wide};
			default:              decoded = {1'b0, data_wide};
		endcase
	end

	// Advance the packet state on each accepted byte
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			pos_q         <= 4'd0;
			in_packet_q   <= 1'b0;
			crc_q         <= 16'h0000;
			header_good_q <= 1'b1;
			id_q          <= 8'h00;
			data_q        <= '0;
			crc_low_q     <= 8'h00;
		end else if (rx_xfer && active) begin
			crc_q         <= crc_next;
			header_good_q <= header_next;
			id_q          <= id_next;
			data_q        <= data_next;
			crc_low_q     <= take_crc_low ? rx.rx_byte : crc_low_base;
			if (finish) begin
				in_packet_q <= 1'b0;
				pos_q       <= 4'd0;
			end else begin
				in_packet_q <= 1'b1;
				pos_q       <= pos_base + 4'd1;
			end
		end
	end

	// Hold the result until it is transferred
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (rx_xfer && (truncate || (active && finish))) begin
			out_valid_q <= 1'b1;
		end else if (result.ready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (rx_xfer && truncate) begin
			out_status_q <= sspc_pkg::STATUS_TRUNCATED;
			out_id_q     <= id_q;
			out_value_q  <= '0;
		end else if (rx_xfer && active && finish) begin
			out_status_q <= fin_status;
			out_id_q     <= id_next;
			out_value_q  <= (fin_status == sspc_pkg::STATUS_OK) ? decoded : '0;
		end
	end

	assign result.valid    = out_valid_q;
	assign result.status   = out_status_q;
	assign result.reply_id = out_id_q;
	assign result.value    = out_value_q;

endmodule

@@ test/tb.sv @@
// Testbench for servo_status_packet_checker: byte-level stimulus with a built-in packet model.
// Depends on sspc_pkg, the sspc_in_if/sspc_out_if/sspc_cfg_if interfaces and the block's RTL.
`timescale 1ns / 100ps

module tb;
	import sspc_pkg::*;

	localparam int          DATA_CAP      = 4;
	localparam logic [31:0] HDR_WORD      = 32'hFFFF_FD00;
	localparam logic [7:0]  INSTR_STATUS  = 8'h55;
	localparam logic [2:0]  FMT_SPARE6    = 3'd6;
	localparam logic [2:0]  FMT_SPARE7    = 3'd7;
	localparam int          SEGMENTS      = 6;
	localparam int          SEG_BYTES     = 170;
	localparam int          SETTLE_CYCLES = 4;

	typedef struct packed {
		status_t            status;
		logic [7:0]         reply_id;
		logic signed [32:0] value;
	} reply_t;

	typedef enum logic [2:0] {
		ROW_GOOD, ROW_BAD_HDR, ROW_BAD_CRC, ROW_BAD_BOTH, ROW_CUT, ROW_NOISE
	} row_kind_t;

	typedef struct packed {
		logic [7:0]         want_id;
		logic               chk;
		logic [2:0]         fmt;
		row_kind_t          kind;
		logic [7:0]         id;
		logic [31:0]        data;
		logic [3:0]         cut;
		logic               typed;
		status_t            st;
		logic signed [32:0] val;
	} dir_row_t;

	logic clk;
	logic arst_n;

	sspc_in_if  rx_if ();
	sspc_out_if res_if ();
	sspc_cfg_if cfg_if ();

	servo_status_packet_checker u_top (
		.clk    (clk),
		.arst_n (arst_n),
		.rx     (rx_if),
		.result (res_if),
		.cfg    (cfg_if)
	);

	// Register copies and packet state of the prediction
	logic [7:0]  cfg_want_id = EXPECTED_ID_RESET;
	logic        cfg_chk     = 1'b1;
	logic [2:0]  cfg_fmt     = DATA_FORMAT_RESET;
	logic [3:0]  frame_pos   = '0;
	logic        frame_open  = 1'b0;
	logic [15:0] crc_acc     = '0;
	logic        hdr_ok      = 1'b1;
	logic [7:0]  frame_id    = '0;
	logic [31:0] data_acc    = '0;
	logic [7:0]  crc_lo      = '0;

	reply_t      reply_q [$];
	reply_t      typed_reply;
	logic        typed_pending = 1'b0;
	int          mism_cnt      = 0;
	int          bytes_sent    = 0;
	int          src_pct       = 15;
	int          snk_pct       = 54;
	dir_row_t    dir_tab [21];

	initial clk = 1'b0;
	always begin
		#5 clk = 1'b1;
		#5 clk = 1'b0;
	end

	// Bound the run in case a handshake never completes
	initial begin
		#5_000_000;
		$display("tb: failure");
		$finish;
	end

	function automatic int fmt_bytes(input logic [2:0] f);
		int s;
		if (f <= FMT_UINT8) s = 1;
		else if (f <= FMT_UINT16) s = 2;
		else s = 4;
		return (s > DATA_CAP) ? DATA_CAP : s;
	endfunction

	function automatic logic [15:0] crc_next(input logic [15:0] c, input logic [7:0] b);
		logic [15:0] r;
		r = c ^ {b, 8'h00};
		for (int k = 0; k < 8; k++)
			r = r[15] ? ((r << 1) ^ CRC_POLY) : (r << 1);
		return r;
	endfunction

	// Sign or zero extend the assembled data bytes by the type
	function automatic logic signed [32:0] widen(input logic [31:0] d, input logic [2:0] f);
		logic signed [32:0] v;
		case (f)
			FMT_INT8:   v = {{25{d[7]}}, d[7:0]};
			FMT_UINT8:  v = {25'd0, d[7:0]};
			FMT_INT16:  v = {{17{d[15]}}, d[15:0]};
			FMT_UINT16: v = {17'd0, d[15:0]};
			FMT_INT32:  v = {d[31], d};
			default:    v = {1'b0, d};
		endcase
		return v;
	endfunction

	// Advance the packet model by one accepted byte; return 1 when it yields a result
	function automatic bit predict_byte(input logic [7:0] b, input logic st, output reply_t r);
		bit          hit;
		int          sz;
		int          total;
		int          p;
		status_t     code;
		logic [15:0] rx_crc;
		hit = 0;
		r = '0;
		if (st) begin
			if (frame_open) begin
				r = '{STATUS_TRUNCATED, frame_id, 33'sd0};
				hit = 1;
			end
			frame_open = 1'b1;
			frame_pos = '0;
			crc_acc = '0;
			hdr_ok = 1'b1;
			frame_id = '0;
			data_acc = '0;
			crc_lo = '0;
		end else if (!frame_open) begin
			return 0;
		end
		sz = fmt_bytes(cfg_fmt);
		total = 11 + sz;
		p = frame_pos;
		if (p + 2 < total) begin
			crc_acc = crc_next(crc_acc, b);
			if (p < 4) begin
				if (b != HDR_WORD[31 - 8 * p -: 8]) hdr_ok = 1'b0;
			end else if (p == 4) begin
				frame_id = b;
			end else if (p >= 9 && p - 9 < sz) begin
				data_acc |= 32'(b) << (8 * (p - 9));
			end
		end else if (p + 2 == total) begin
			crc_lo = b;
		end
		if (p + 1 >= total) begin
			rx_crc = {b, crc_lo};
			if (!hdr_ok) code = STATUS_HEADER;
			else if (cfg_chk && frame_id != cfg_want_id) code = STATUS_ID;
			else if (rx_crc != crc_acc) code = STATUS_CRC;
			else code = STATUS_OK;
			r = '{code, frame_id, (code == STATUS_OK) ? widen(data_acc, cfg_fmt) : 33'sd0};
			hit = 1;
			frame_open = 1'b0;
			frame_pos = '0;
		end else begin
			frame_pos = 4'(p + 1);
		end
		return hit;
	endfunction

	task automatic note_mismatch(input string what, input reply_t want, input reply_t got);
		mism_cnt++;
		if (mism_cnt <= 10)
			$display({"mismatch (%s): expected status %0d id %0d value %0d, ",
				"got status %0d id %0d value %0d"},
				what, want.status, want.reply_id, $signed(want.value),
				got.status, got.reply_id, $signed(got.value));
	endtask

	// Check results first, then predict from accepted bytes and track register writes
	always @(posedge clk) begin : monitor
		reply_t got;
		reply_t want;
		reply_t pred;
		if (arst_n) begin
			if (res_if.valid === 1'b1 && res_if.ready === 1'b1) begin
				got = '{status_t'(res_if.status), res_if.reply_id, res_if.value};
				if (reply_q.size() == 0) begin
					note_mismatch("no result pending", got, got);
				end else begin
					want = reply_q.pop_front();
					if (got.status !== want.status || got.reply_id !== want.reply_id ||
							got.value !== want.value)
						note_mismatch("field", want, got);
				end
			end
			if (rx_if.valid === 1'b1 && rx_if.ready === 1'b1) begin
				if (predict_byte(rx_if.rx_byte, rx_if.packet_start, pred)) begin
					if (typed_pending && pred.status != STATUS_TRUNCATED) begin
						pred = typed_reply;
						typed_pending = 1'b0;
					end
					reply_q.push_back(pred);
				end
			end
			if (cfg_if.valid === 1'b1 && cfg_if.ready === 1'b1) begin
				case (cfg_index_t'(cfg_if.index))
					REG_EXPECTED_ID: cfg_want_id = cfg_if.data;
					REG_CHECK_ID:    cfg_chk = cfg_if.data[0];
					REG_DATA_FORMAT: cfg_fmt = cfg_if.data[2:0];
					default: ;
				endcase
			end
		end
	end

	// Stall the result channel at random
	always @(negedge clk)
		res_if.ready <= ($urandom_range(99) >= snk_pct);

	// Send one byte; called and returns at a falling edge, valid left high
	task automatic send_byte(input logic [7:0] b, input logic st);
		while ($urandom_range(99) < src_pct) begin
			rx_if.valid <= 1'b0;
			rx_if.rx_byte <= 8'($urandom_range(255));
			@(negedge clk);
		end
		rx_if.valid <= 1'b1;
		rx_if.rx_byte <= b;
		rx_if.packet_start <= st;
		@(posedge clk);
		while (rx_if.ready !== 1'b1) @(posedge clk);
		bytes_sent++;
		@(negedge clk);
	endtask

	// Build a status packet for the current format, optionally damaged or cut short
	task automatic send_packet(input logic [7:0] id, input logic [31:0] data,
			input logic bad_hdr, input logic bad_crc, input int cut);
		logic [7:0]  pkt [$];
		logic [15:0] crc;
		int          sz;
		int          n;
		int          hp;
		sz = fmt_bytes(cfg_fmt);
		pkt = {8'hFF, 8'hFF, 8'hFD, 8'h00, id, 8'(sz + 4), 8'h00, INSTR_STATUS,
			8'($urandom_range(255))};
		for (int k = 0; k < sz; k++)
			pkt.push_back(data[8 * k +: 8]);
		if (bad_hdr) begin
			hp = $urandom_range(3);
			pkt[hp] = pkt[hp] ^ 8'($urandom_range(255, 1));
		end
		crc = '0;
		foreach (pkt[k])
			crc = crc_next(crc, pkt[k]);
		if (bad_crc) crc ^= 16'($urandom_range(65535, 1));
		pkt.push_back(crc[7:0]);
		pkt.push_back(crc[15:8]);
		n = (cut > 0 && cut < pkt.size()) ? cut : pkt.size();
		for (int k = 0; k < n; k++)
			send_byte(pkt[k], k == 0);
	endtask

	// Random bytes; with mixed set, the start flag is raised now and then
	task automatic send_noise(input int n, input logic mixed);
		for (int k = 0; k < n; k++)
			send_byte(8'($urandom_range(255)), mixed ? ($urandom_range(7) == 0) : 1'b0);
	endtask

	// Wait for every pending result, then let the output register empty
	task automatic drain_results;
		while (reply_q.size() != 0) @(posedge clk);
		repeat (SETTLE_CYCLES) @(posedge clk);
		@(negedge clk);
	endtask

	task automatic cfg_handshake;
		@(posedge clk);
		while (cfg_if.ready !== 1'b1) @(posedge clk);
		@(negedge clk);
	endtask

	// Write all three registers back to back
	task automatic load_regs(input logic [7:0] want, input logic chk, input logic [2:0] fmt);
		cfg_if.valid <= 1'b1;
		cfg_if.index <= REG_EXPECTED_ID;
		cfg_if.data <= want;
		cfg_handshake();
		cfg_if.index <= REG_CHECK_ID;
		cfg_if.data <= {7'd0, chk};
		cfg_handshake();
		cfg_if.index <= REG_DATA_FORMAT;
		cfg_if.data <= {5'd0, fmt};
		cfg_handshake();
		cfg_if.valid <= 1'b0;
	endtask

	// Random packets, mostly well formed, ending in a closing good packet
	task automatic run_segment(input int nbytes);
		int          start_cnt;
		int          r;
		logic [7:0]  id;
		logic [31:0] data;
		start_cnt = bytes_sent;
		while (bytes_sent - start_cnt < nbytes) begin
			r = $urandom_range(99);
			id = ($urandom_range(3) == 0) ? 8'($urandom_range(255)) : cfg_want_id;
			data = ($urandom_range(7) == 0) ?
				($urandom_range(1) ? 32'hFFFF_FFFF : 32'h0) : $urandom();
			if (r < 60) send_packet(id, data, 1'b0, 1'b0, 0);
			else if (r < 70) send_packet(id, data, 1'b1, 1'b0, 0);
			else if (r < 80) send_packet(id, data, 1'b0, 1'b1, 0);
			else if (r < 88) send_packet(id, data, 1'b0, 1'b0,
				$urandom_range(fmt_bytes(cfg_fmt) + 10, 1));
			else if (r < 94) send_noise($urandom_range(4, 1), 1'b0);
			else send_noise($urandom_range(15, 1), 1'b1);
		end
		send_packet(cfg_want_id, $urandom(), 1'b0, 1'b0, 0);
		rx_if.valid <= 1'b0;
	endtask

	initial begin : stimulus
		dir_row_t row;
		arst_n = 1'b0;
		rx_if.valid = 1'b0;
		rx_if.rx_byte = '0;
		rx_if.packet_start = 1'b0;
		cfg_if.valid = 1'b0;
		cfg_if.index = REG_EXPECTED_ID;
		cfg_if.data = '0;
		res_if.ready = 1'b0;

		// want_id chk fmt kind id data cut typed status value
		dir_tab = '{
			'{8'd1, 1'b1, FMT_INT32, ROW_GOOD, 8'd1, 32'h8000_0000, 4'd0, 1'b1,
				STATUS_OK, 33'h1_8000_0000},
			'{8'd1, 1'b1, FMT_INT32, ROW_GOOD, 8'd1, 32'h7FFF_FFFF, 4'd0, 1'b1,
				STATUS_OK, 33'h0_7FFF_FFFF},
			'{8'd1, 1'b1, FMT_INT32, ROW_BAD_HDR, 8'd1, 32'h1234_5678, 4'd0, 1'b1,
				STATUS_HEADER, 33'h0},
			'{8'd1, 1'b1, FMT_INT32, ROW_GOOD, 8'd2, 32'h1234_5678, 4'd0, 1'b1,
				STATUS_ID, 33'h0},
			'{8'd1, 1'b1, FMT_INT32, ROW_BAD_CRC, 8'd1, 32'h1234_5678, 4'd0, 1'b1,
				STATUS_CRC, 33'h0},
			// header error outranks the ID and CRC errors
			'{8'd1, 1'b1, FMT_INT32, ROW_BAD_BOTH, 8'd7, 32'hDEAD_BEEF, 4'd0, 1'b1,
				STATUS_HEADER, 33'h0},
			// ID mismatch outranks a CRC error
			'{8'd1, 1'b1, FMT_INT32, ROW_BAD_CRC, 8'd9, 32'hDEAD_BEEF, 4'd0, 1'b1,
				STATUS_ID, 33'h0},
			// bytes outside a packet are ignored
			'{8'd1, 1'b1, FMT_INT32, ROW_NOISE, 8'd0, 32'h0, 4'd3, 1'b0,
				STATUS_OK, 33'h0},
			// restarts in the middle of a packet, after the ID and right after start
			'{8'd1, 1'b1, FMT_INT32, ROW_CUT, 8'd1, 32'h0, 4'd6, 1'b0,
				STATUS_OK, 33'h0},
			'{8'd1, 1'b1, FMT_INT32, ROW_CUT, 8'd1, 32'h0, 4'd1, 1'b0,
				STATUS_OK, 33'h0},
			'{8'd1, 1'b1, FMT_INT32, ROW_GOOD, 8'd1, 32'h0, 4'd0, 1'b1,
				STATUS_OK, 33'h0},
			'{8'd0, 1'b1, FMT_INT8, ROW_GOOD, 8'd0, 32'h0000_0080, 4'd0, 1'b1,
				STATUS_OK, 33'h1_FFFF_FF80},
			// cut one byte short of the end, then restart
			'{8'd0, 1'b1, FMT_INT8, ROW_CUT, 8'd0, 32'h0000_0055, 4'd11, 1'b0,
				STATUS_OK, 33'h0},
			'{8'd0, 1'b1, FMT_INT8, ROW_GOOD, 8'd0, 32'h0000_007F, 4'd0, 1'b1,
				STATUS_OK, 33'h0_0000_007F},
			// ID check off: any ID passes
			'{8'd253, 1'b0, FMT_UINT8, ROW_GOOD, 8'd255, 32'h0000_00FF, 4'd0, 1'b1,
				STATUS_OK, 33'h0_0000_00FF},
			'{8'd253, 1'b1, FMT_INT16, ROW_GOOD, 8'd253, 32'h0000_8000, 4'd0, 1'b1,
				STATUS_OK, 33'h1_FFFF_8000},
			'{8'd253, 1'b1, FMT_UINT16, ROW_GOOD, 8'd253, 32'h0000_FFFF, 4'd0, 1'b1,
				STATUS_OK, 33'h0_0000_FFFF},
			'{8'd253, 1'b1, FMT_UINT32, ROW_GOOD, 8'd253, 32'hFFFF_FFFF, 4'd0, 1'b1,
				STATUS_OK, 33'h0_FFFF_FFFF},
			// spare format codes decode as uint32
			'{8'd253, 1'b1, FMT_SPARE6, ROW_GOOD, 8'd253, 32'h8000_0001, 4'd0, 1'b1,
				STATUS_OK, 33'h0_8000_0001},
			'{8'd253, 1'b1, FMT_SPARE7, ROW_GOOD, 8'd253, 32'hFFFF_FFFF, 4'd0, 1'b1,
				STATUS_OK, 33'h0_FFFF_FFFF},
			'{8'd253, 1'b0, FMT_SPARE7, ROW_BAD_CRC, 8'd0, 32'h0000_0001, 4'd0, 1'b1,
				STATUS_CRC, 33'h0}
		};

		repeat (8) @(posedge clk);
		@(negedge clk);
		arst_n = 1'b1;

		// Directed rows; rewrite registers only between whole packets
		foreach (dir_tab[i]) begin
			row = dir_tab[i];
			if (row.want_id != cfg_want_id || row.chk != cfg_chk ||
					row.fmt != cfg_fmt) begin
				rx_if.valid <= 1'b0;
				drain_results();
				load_regs(row.want_id, row.chk, row.fmt);
			end
			if (row.typed) begin
				typed_reply = '{row.st, row.id, row.val};
				typed_pending = 1'b1;
			end
			case (row.kind)
				ROW_GOOD:     send_packet(row.id, row.data, 1'b0, 1'b0, 0);
				ROW_BAD_HDR:  send_packet(row.id, row.data, 1'b1, 1'b0, 0);
				ROW_BAD_CRC:  send_packet(row.id, row.data, 1'b0, 1'b1, 0);
				ROW_BAD_BOTH: send_packet(row.id, row.data, 1'b1, 1'b1, 0);
				ROW_CUT:      send_packet(row.id, row.data, 1'b0, 1'b0, row.cut);
				default:      send_noise(row.cut, 1'b0);
			endcase
		end
		rx_if.valid <= 1'b0;

		// Random segments, two per idling profile, fresh registers for each
		for (int seg = 0; seg < SEGMENTS; seg++) begin
			case (seg / 2)
				0: begin
					src_pct = 15;
					snk_pct = 54;
				end
				1: begin
					src_pct = 54;
					snk_pct = 15;
				end
				default: begin
					src_pct = 0;
					snk_pct = 0;
				end
			endcase
			drain_results();
			if (seg == 0) load_regs(8'd0, 1'b1, FMT_INT8);
			else if (seg == 1) load_regs(8'd253, 1'b0, FMT_UINT32);
			else load_regs(8'($urandom_range(253)), 1'($urandom_range(1)),
				3'($urandom_range(7)));
			run_segment(SEG_BYTES);
		end

		drain_results();
		if (mism_cnt == 0 && reply_q.size() == 0)
			$display("tb: success");
		else
			$display("tb: failure");
		$finish;
	end

endmodule
